### hw/rtl/keypad_setpoint_entry_defines.svh
// assertion macros shared by the keypad setpoint entry modules
// all of them sample on clk_i and are disabled while rst_ni is low
`ifndef KEYPAD_SETPOINT_ENTRY_DEFINES_SVH
`define KEYPAD_SETPOINT_ENTRY_DEFINES_SVH

`ifndef SYNTH
`define KSE_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("assertion failed");
`define KSE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define KSE_ASSERT_ALWAYS(lbl, expr)
`define KSE_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### hw/rtl/kse_pkg.sv
package kse_pkg;

  localparam int unsigned MAX_DIGITS = 3;

  localparam int unsigned KeyW   = 12;
  localparam int unsigned IdxW   = 4;
  localparam int unsigned ValW   = 14;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [IdxW-1:0] KEY_STAR = 4'd9;
  localparam logic [IdxW-1:0] KEY_ZERO = 4'd10;
  localparam logic [IdxW-1:0] KEY_HASH = 4'd11;

  localparam logic [ValW-1:0]  TEMP_MIN_RST   = 14'd5;
  localparam logic [ValW-1:0]  TEMP_MAX_RST   = 14'd40;
  localparam logic [ValW-1:0]  HUM_MIN_RST    = 14'd20;
  localparam logic [ValW-1:0]  HUM_MAX_RST    = 14'd90;
  localparam logic [TimeW-1:0] STAR_WINDOW_RST = 32'd10000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TEMP_MIN    = 3'd0,
    CFG_TEMP_MAX    = 3'd1,
    CFG_HUM_MIN     = 3'd2,
    CFG_HUM_MAX     = 3'd3,
    CFG_STAR_WINDOW = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    EV_NONE      = 4'd0,
    EV_DIGIT     = 4'd1,
    EV_TOO_LONG  = 4'd2,
    EV_TEMP_START = 4'd3,
    EV_HUM_START = 4'd4,
    EV_TEMP_OK   = 4'd5,
    EV_HUM_OK    = 4'd6,
    EV_TEMP_BAD  = 4'd7,
    EV_HUM_BAD   = 4'd8,
    EV_ALARM_ACK = 4'd9
  } ev_e;

  typedef struct packed {
    logic [ValW-1:0]  temp_min;
    logic [ValW-1:0]  temp_max;
    logic [ValW-1:0]  hum_min;
    logic [ValW-1:0]  hum_max;
    logic [TimeW-1:0] star_window;
  } cfg_t;

  typedef struct packed {
    logic            valid;
    logic [IdxW-1:0] index;
    logic [2:0]      row;
    logic [1:0]      col;
  } key_t;

  typedef struct packed {
    logic [1:0]      mode;
    logic [2:0]      digits;
    logic [ValW-1:0] value;
    ev_e             ev;
    logic [ValW-1:0] setpoint;
  } res_t;

  function automatic logic [2:0] key_row(input logic [IdxW-1:0] idx);
    logic [2:0] r;
    case (idx)
      4'd0, 4'd1, 4'd2:   r = 3'd1;
      4'd3, 4'd4, 4'd5:   r = 3'd2;
      4'd6, 4'd7, 4'd8:   r = 3'd3;
      4'd9, 4'd10, 4'd11: r = 3'd4;
      default:            r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] key_col(input logic [IdxW-1:0] idx);
    logic [1:0] c;
    case (idx)
      4'd0, 4'd3, 4'd6, 4'd9:  c = 2'd1;
      4'd1, 4'd4, 4'd7, 4'd10: c = 2'd2;
      4'd2, 4'd5, 4'd8, 4'd11: c = 2'd3;
      default:                 c = 2'd0;
    endcase
    return c;
  endfunction

endpackage

### hw/rtl/kse_cfg_regs.sv
module kse_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  input  logic [kse_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [kse_pkg::TimeW-1:0]   cfg_data_i,
  output kse_pkg::cfg_t               cfg_o
);

  kse_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        kse_pkg::CFG_TEMP_MIN:    cfg_d.temp_min    = cfg_data_i[kse_pkg::ValW-1:0];
        kse_pkg::CFG_TEMP_MAX:    cfg_d.temp_max    = cfg_data_i[kse_pkg::ValW-1:0];
        kse_pkg::CFG_HUM_MIN:     cfg_d.hum_min     = cfg_data_i[kse_pkg::ValW-1:0];
        kse_pkg::CFG_HUM_MAX:     cfg_d.hum_max     = cfg_data_i[kse_pkg::ValW-1:0];
        kse_pkg::CFG_STAR_WINDOW: cfg_d.star_window = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.temp_min    <= kse_pkg::TEMP_MIN_RST;
      cfg_q.temp_max    <= kse_pkg::TEMP_MAX_RST;
      cfg_q.hum_min     <= kse_pkg::HUM_MIN_RST;
      cfg_q.hum_max     <= kse_pkg::HUM_MAX_RST;
      cfg_q.star_window <= kse_pkg::STAR_WINDOW_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hw/rtl/kse_key_scan.sv
module kse_key_scan (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     step_i,
  input  logic [kse_pkg::KeyW-1:0] pressed_i,
  output kse_pkg::key_t            key_o
);

  logic [kse_pkg::KeyW-1:0] prev_q;
  logic [2:0]               row_q, row_d;
  logic [1:0]               col_q, col_d;
  logic [kse_pkg::KeyW-1:0] fresh;
  logic [kse_pkg::IdxW-1:0] idx;
  logic                     found;

  assign fresh = pressed_i & ~prev_q;
  assign found = |fresh;

  // lowest set bit wins
  always_comb begin
    idx = '0;
    for (int i = kse_pkg::KeyW - 1; i >= 0; i--) begin
      if (fresh[i]) begin
        idx = kse_pkg::IdxW'(i);
      end
    end
  end

  assign row_d = found ? kse_pkg::key_row(idx) : row_q;
  assign col_d = found ? kse_pkg::key_col(idx) : col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      row_q  <= '0;
      col_q  <= '0;
    end else if (step_i) begin
      prev_q <= pressed_i;
      row_q  <= row_d;
      col_q  <= col_d;
    end
  end

  assign key_o.valid = found;
  assign key_o.index = idx;
  assign key_o.row   = row_d;
  assign key_o.col   = col_d;

endmodule

### hw/rtl/kse_entry_ctrl.sv
`include "keypad_setpoint_entry_defines.svh"

module kse_entry_ctrl #(
  parameter int unsigned MaxDigits = kse_pkg::MAX_DIGITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  kse_pkg::key_t             key_i,
  input  logic [kse_pkg::TimeW-1:0] now_i,
  input  kse_pkg::cfg_t             cfg_i,
  output kse_pkg::res_t             res_o
);

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_TEMP = 2'd1,
    MODE_HUM  = 2'd2
  } mode_e;

  mode_e                     mode_q, mode_d;
  logic [2:0]                digits_q, digits_d;
  logic [kse_pkg::ValW-1:0]  value_q, value_d;
  logic [kse_pkg::TimeW-1:0] star_q, star_d;

  logic [2:0]                dig_base;
  logic [kse_pkg::ValW-1:0]  val_base;
  logic [kse_pkg::ValW-1:0]  digit;
  logic [kse_pkg::ValW-1:0]  val_next;
  logic [kse_pkg::TimeW-1:0] since_star;
  logic                      is_cmd;
  logic                      in_temp, in_hum;
  kse_pkg::ev_e              ev;
  logic [kse_pkg::ValW-1:0]  setpoint;

  assign is_cmd     = (key_i.index == kse_pkg::KEY_STAR) || (key_i.index == kse_pkg::KEY_HASH);
  assign since_star = now_i - star_q;
  assign digit      = (key_i.index == kse_pkg::KEY_ZERO) ? '0
                    : kse_pkg::ValW'(key_i.index) + kse_pkg::ValW'(1);
  assign in_temp    = (value_q >= cfg_i.temp_min) && (value_q <= cfg_i.temp_max);
  assign in_hum     = (value_q >= cfg_i.hum_min) && (value_q <= cfg_i.hum_max);

  // a first digit in idle starts from an empty entry
  assign dig_base = (mode_q == MODE_IDLE) ? '0 : digits_q;
  assign val_base = (mode_q == MODE_IDLE) ? '0 : value_q;
  assign val_next = {val_base[kse_pkg::ValW-4:0], 3'b000}
                  + {val_base[kse_pkg::ValW-2:0], 1'b0} + digit;

  always_comb begin
    mode_d   = mode_q;
    digits_d = digits_q;
    value_d  = value_q;
    star_d   = star_q;
    ev       = kse_pkg::EV_NONE;
    setpoint = '0;
    if (key_i.valid) begin
      if (is_cmd) begin
        digits_d = '0;
        value_d  = '0;
        if (mode_q != MODE_IDLE && digits_q != '0) begin
          mode_d = MODE_IDLE;
          if (mode_q == MODE_TEMP) begin
            ev       = in_temp ? kse_pkg::EV_TEMP_OK : kse_pkg::EV_TEMP_BAD;
            setpoint = in_temp ? value_q : '0;
          end else begin
            ev       = in_hum ? kse_pkg::EV_HUM_OK : kse_pkg::EV_HUM_BAD;
            setpoint = in_hum ? value_q : '0;
          end
        end else if (key_i.index == kse_pkg::KEY_HASH) begin
          mode_d = MODE_IDLE;
          ev     = kse_pkg::EV_ALARM_ACK;
        end else if (mode_q == MODE_TEMP && since_star < cfg_i.star_window) begin
          mode_d = MODE_HUM;
          star_d = '0;
          ev     = kse_pkg::EV_HUM_START;
        end else begin
          mode_d = MODE_TEMP;
          star_d = now_i;
          ev     = kse_pkg::EV_TEMP_START;
        end
      end else begin
        if (mode_q == MODE_IDLE) begin
          mode_d = MODE_TEMP;
        end
        if (dig_base >= 3'(MaxDigits)) begin
          digits_d = dig_base;
          value_d  = val_base;
          ev       = kse_pkg::EV_TOO_LONG;
        end else begin
          digits_d = dig_base + 3'd1;
          value_d  = val_next;
          ev       = kse_pkg::EV_DIGIT;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      digits_q <= '0;
      value_q  <= '0;
      star_q   <= '0;
    end else if (step_i) begin
      mode_q   <= mode_d;
      digits_q <= digits_d;
      value_q  <= value_d;
      star_q   <= star_d;
    end
  end

  assign res_o.mode     = mode_d;
  assign res_o.digits   = digits_d;
  assign res_o.value    = value_d;
  assign res_o.ev       = ev;
  assign res_o.setpoint = setpoint;

  `KSE_ASSERT_ALWAYS(a_digits_bound, digits_q <= 3'(MaxDigits))
  `KSE_ASSERT_ALWAYS(a_idle_empty, (mode_q != MODE_IDLE) || (digits_q == '0))
  `KSE_ASSERT_ALWAYS(a_empty_zero, (digits_q != '0) || (value_q == '0))
  `KSE_ASSERT_NEXT(a_no_key_hold, !key_i.valid, $stable(mode_q) && $stable(digits_q))

endmodule

### hw/rtl/keypad_setpoint_entry.sv
// keypad setpoint entry
// input channel: in_valid_i / in_ready_o carry one keypad scan per beat,
//   pressed_keys_i (bit (row-1)*3+(col-1) per key) and now_ms_i
// output channel: out_valid_o / out_ready_i carry exactly one result beat
//   per scan: the new key found, the entry state after the scan and the
//   event with its accepted setpoint
// config channel: cfg_valid_i / cfg_ready_o write register cfg_index_i
//   (0 temp_min, 1 temp_max, 2 humidity_min, 3 humidity_max,
//   4 star_window_ms) with cfg_data_i; other indexes are dropped;
//   cfg_ready_o is always high, write only while no scan is in flight
// a scan is taken into the input register, then key pick and entry update
//   feed the result register
// throughput: one scan per cycle while the receiver does not stall, set by
//   the single pass of key pick and entry update between those two registers
// when the receiver stalls the result register holds; one more scan can
//   be taken into the input register, then in_ready_o drops
// reset clears the entry, key history and pipeline valids and loads the
//   default limits and window
module keypad_setpoint_entry #(
  parameter int unsigned MaxDigits = kse_pkg::MAX_DIGITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [kse_pkg::KeyW-1:0]    pressed_keys_i,
  input  logic [kse_pkg::TimeW-1:0]   now_ms_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        key_valid_o,
  output logic [kse_pkg::IdxW-1:0]    key_index_o,
  output logic [2:0]                  key_row_o,
  output logic [1:0]                  key_col_o,
  output logic [1:0]                  entry_mode_o,
  output logic [2:0]                  digit_count_o,
  output logic [kse_pkg::ValW-1:0]    entry_value_o,
  output logic [3:0]                  event_res_o,
  output logic [kse_pkg::ValW-1:0]    setpoint_value_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [kse_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [kse_pkg::TimeW-1:0]   cfg_data_i
);

  logic                      in_valid_q, in_valid_d;
  logic [kse_pkg::KeyW-1:0]  pressed_q;
  logic [kse_pkg::TimeW-1:0] now_q;
  logic                      out_valid_q, out_valid_d;
  kse_pkg::key_t             key_q;
  kse_pkg::res_t             res_q;

  logic                      advance;
  logic                      in_accept;
  kse_pkg::cfg_t             cfg;
  kse_pkg::key_t             key;
  kse_pkg::res_t             res;

  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign in_accept   = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  assign in_valid_d  = in_accept ? 1'b1 : (advance ? 1'b0 : in_valid_q);
  assign out_valid_d = advance ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  kse_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  kse_key_scan u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .pressed_i (pressed_q),
    .key_o     (key)
  );

  kse_entry_ctrl #(
    .MaxDigits (MaxDigits)
  ) u_entry (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .key_i  (key),
    .now_i  (now_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      pressed_q <= pressed_keys_i;
      now_q     <= now_ms_i;
    end
    if (advance) begin
      key_q <= key;
      res_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign key_valid_o      = key_q.valid;
  assign key_index_o      = key_q.index;
  assign key_row_o        = key_q.row;
  assign key_col_o        = key_q.col;
  assign entry_mode_o     = res_q.mode;
  assign digit_count_o    = res_q.digits;
  assign entry_value_o    = res_q.value;
  assign event_res_o      = res_q.ev;
  assign setpoint_value_o = res_q.setpoint;

endmodule

### bench/keypad_setpoint_entry_checker.sv
`timescale 1ns / 100ps

module keypad_setpoint_entry_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic [kse_pkg::KeyW-1:0]    pressed_keys_i,
  input  logic [kse_pkg::TimeW-1:0]   now_ms_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic                        key_valid_i,
  input  logic [kse_pkg::IdxW-1:0]    key_index_i,
  input  logic [2:0]                  key_row_i,
  input  logic [1:0]                  key_col_i,
  input  logic [1:0]                  entry_mode_i,
  input  logic [2:0]                  digit_count_i,
  input  logic [kse_pkg::ValW-1:0]    entry_value_i,
  input  logic [3:0]                  event_res_i,
  input  logic [kse_pkg::ValW-1:0]    setpoint_value_i,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [kse_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [kse_pkg::TimeW-1:0]   cfg_data_i,
  output int                          fail_count_o,
  output int                          pending_o
);

  import kse_pkg::*;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_TEMP = 2'd1;
  localparam logic [1:0] MODE_HUM  = 2'd2;

  typedef struct packed {
    logic            key_valid;
    logic [IdxW-1:0] key_index;
    logic [2:0]      key_row;
    logic [1:0]      key_col;
    logic [1:0]      mode;
    logic [2:0]      digits;
    logic [ValW-1:0] value;
    ev_e             ev;
    logic [ValW-1:0] setpoint;
  } scan_result_t;

  scan_result_t     awaited_scans[$];
  logic [ValW-1:0]  temp_lo, temp_hi, hum_lo, hum_hi;
  logic [TimeW-1:0] star_window;
  logic [KeyW-1:0]  last_keys;
  logic [1:0]       mode_q;
  logic [2:0]       digits_q;
  logic [ValW-1:0]  value_q;
  logic [TimeW-1:0] star_stamp;
  logic [2:0]       row_q;
  logic [1:0]       col_q;
  int               fails = 0;

  function automatic scan_result_t decode_scan(input logic [KeyW-1:0]  keys,
                                               input logic [TimeW-1:0] stamp);
    scan_result_t     r;
    logic [KeyW-1:0]  fresh;
    logic [IdxW-1:0]  idx;
    logic [ValW-1:0]  digit;
    logic [TimeW-1:0] elapsed;
    logic             in_range;
    r = '0;
    r.ev = EV_NONE;
    fresh = keys & ~last_keys;
    last_keys = keys;
    if (fresh != '0) begin
      idx = '0;
      for (int i = KeyW - 1; i >= 0; i--) begin
        if (fresh[i]) idx = IdxW'(i);
      end
      r.key_valid = 1'b1;
      r.key_index = idx;
      row_q = 3'(idx / 4'd3) + 3'd1;
      col_q = 2'(idx % 4'd3) + 2'd1;
      if (idx == KEY_STAR || idx == KEY_HASH) begin
        elapsed = stamp - star_stamp;
        if (mode_q != MODE_IDLE && digits_q != 3'd0) begin
          if (mode_q == MODE_TEMP) begin
            in_range = (value_q >= temp_lo) && (value_q <= temp_hi);
            r.ev = in_range ? EV_TEMP_OK : EV_TEMP_BAD;
          end else begin
            in_range = (value_q >= hum_lo) && (value_q <= hum_hi);
            r.ev = in_range ? EV_HUM_OK : EV_HUM_BAD;
          end
          if (in_range) r.setpoint = value_q;
          mode_q = MODE_IDLE;
          digits_q = '0;
          value_q = '0;
        end else if (idx == KEY_HASH) begin
          mode_q = MODE_IDLE;
          digits_q = '0;
          value_q = '0;
          r.ev = EV_ALARM_ACK;
        end else if (mode_q == MODE_TEMP && digits_q == 3'd0 && elapsed < star_window) begin
          mode_q = MODE_HUM;
          digits_q = '0;
          value_q = '0;
          star_stamp = '0;
          r.ev = EV_HUM_START;
        end else begin
          mode_q = MODE_TEMP;
          digits_q = '0;
          value_q = '0;
          star_stamp = stamp;
          r.ev = EV_TEMP_START;
        end
      end else begin
        digit = (idx == KEY_ZERO) ? '0 : ValW'(idx) + 14'd1;
        if (mode_q == MODE_IDLE) begin
          mode_q = MODE_TEMP;
          digits_q = '0;
          value_q = '0;
        end
        if (32'(digits_q) >= MAX_DIGITS) begin
          r.ev = EV_TOO_LONG;
        end else begin
          value_q = value_q * 14'd10 + digit;
          digits_q = digits_q + 3'd1;
          r.ev = EV_DIGIT;
        end
      end
    end
    r.key_row = row_q;
    r.key_col = col_q;
    r.mode    = mode_q;
    r.digits  = digits_q;
    r.value   = value_q;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    scan_result_t want;
    if (!rst_ni) begin
      temp_lo     = TEMP_MIN_RST;
      temp_hi     = TEMP_MAX_RST;
      hum_lo      = HUM_MIN_RST;
      hum_hi      = HUM_MAX_RST;
      star_window = STAR_WINDOW_RST;
      last_keys   = '0;
      mode_q      = MODE_IDLE;
      digits_q    = '0;
      value_q     = '0;
      star_stamp  = '0;
      row_q       = '0;
      col_q       = '0;
      awaited_scans.delete();
      pending_o <= 0;
      fail_count_o <= fails;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_TEMP_MIN:    temp_lo = cfg_data_i[ValW-1:0];
          CFG_TEMP_MAX:    temp_hi = cfg_data_i[ValW-1:0];
          CFG_HUM_MIN:     hum_lo = cfg_data_i[ValW-1:0];
          CFG_HUM_MAX:     hum_hi = cfg_data_i[ValW-1:0];
          CFG_STAR_WINDOW: star_window = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (awaited_scans.size() == 0) begin
          $error("result beat with no scan outstanding");
          fails++;
        end else begin
          want = awaited_scans.pop_front();
          check_field("key_valid", 32'(want.key_valid), 32'(key_valid_i));
          check_field("key_index", 32'(want.key_index), 32'(key_index_i));
          check_field("key_row", 32'(want.key_row), 32'(key_row_i));
          check_field("key_col", 32'(want.key_col), 32'(key_col_i));
          check_field("entry_mode", 32'(want.mode), 32'(entry_mode_i));
          check_field("digit_count", 32'(want.digits), 32'(digit_count_i));
          check_field("entry_value", 32'(want.value), 32'(entry_value_i));
          check_field("event_res", 32'(want.ev), 32'(event_res_i));
          check_field("setpoint_value", 32'(want.setpoint), 32'(setpoint_value_i));
        end
      end
      if (in_valid_i && in_ready_i) begin
        awaited_scans.push_back(decode_scan(pressed_keys_i, now_ms_i));
      end
      pending_o <= awaited_scans.size();
      fail_count_o <= fails;
    end
  end

endmodule

### bench/keypad_setpoint_entry_tb.sv
`timescale 1ns / 100ps

module keypad_setpoint_entry_tb;

  import kse_pkg::*;

  localparam int CYCLE_LIMIT      = 200000;
  localparam int RANDOM_PER_PHASE = 280;
  localparam int HOLD_CYCLES      = 250;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                in_valid_i     = 1'b0;
  logic [KeyW-1:0]     pressed_keys_i = '0;
  logic [TimeW-1:0]    now_ms_i       = '0;
  logic                out_ready_i    = 1'b0;
  logic                cfg_valid_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i    = '0;
  logic [TimeW-1:0]    cfg_data_i     = '0;

  logic                in_ready_o;
  logic                out_valid_o;
  logic                key_valid_o;
  logic [IdxW-1:0]     key_index_o;
  logic [2:0]          key_row_o;
  logic [1:0]          key_col_o;
  logic [1:0]          entry_mode_o;
  logic [2:0]          digit_count_o;
  logic [ValW-1:0]     entry_value_o;
  logic [3:0]          event_res_o;
  logic [ValW-1:0]     setpoint_value_o;
  logic                cfg_ready_o;

  int                  fail_count;
  int                  pending;
  int                  sent_items  = 0;
  int                  burst_left  = 0;
  int                  cycles      = 0;
  logic [TimeW-1:0]    clock_ms    = '0;
  logic [KeyW-1:0]     held_keys   = '0;
  logic [TimeW-1:0]    win_setting = STAR_WINDOW_RST;
  bit                  hold_req    = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  keypad_setpoint_entry DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .pressed_keys_i   (pressed_keys_i),
    .now_ms_i         (now_ms_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .key_valid_o      (key_valid_o),
    .key_index_o      (key_index_o),
    .key_row_o        (key_row_o),
    .key_col_o        (key_col_o),
    .entry_mode_o     (entry_mode_o),
    .digit_count_o    (digit_count_o),
    .entry_value_o    (entry_value_o),
    .event_res_o      (event_res_o),
    .setpoint_value_o (setpoint_value_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  keypad_setpoint_entry_checker result_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .pressed_keys_i   (pressed_keys_i),
    .now_ms_i         (now_ms_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .key_valid_i      (key_valid_o),
    .key_index_i      (key_index_o),
    .key_row_i        (key_row_o),
    .key_col_i        (key_col_o),
    .entry_mode_i     (entry_mode_o),
    .digit_count_i    (digit_count_o),
    .entry_value_i    (entry_value_o),
    .event_res_i      (event_res_o),
    .setpoint_value_i (setpoint_value_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  function automatic logic [IdxW-1:0] digit_key(input int unsigned d);
    return (d == 0) ? KEY_ZERO : IdxW'(d - 1);
  endfunction

  function automatic logic [KeyW-1:0] key_mask(input logic [IdxW-1:0] k);
    return KeyW'(1) << k;
  endfunction

  function automatic logic [TimeW-1:0] short_dt();
    return $urandom_range(0, 300);
  endfunction

  // sender: bursts of beats with random gaps between them
  task automatic send_scan(input logic [KeyW-1:0] keys, input logic [TimeW-1:0] dt);
    int gap;
    clock_ms = clock_ms + dt;
    held_keys = keys;
    in_valid_i <= 1'b1;
    pressed_keys_i <= keys;
    now_ms_i <= clock_ms;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent_items++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic press_key(input logic [IdxW-1:0] k, input logic [TimeW-1:0] dt);
    if (held_keys[k] || $urandom_range(0, 3) == 0) send_scan('0, '0);
    if ($urandom_range(0, 3) == 0) send_scan(held_keys | key_mask(k), dt);
    else send_scan(key_mask(k), dt);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [TimeW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CFG_STAR_WINDOW) win_setting = data;
  endtask

  task automatic configure(input logic [TimeW-1:0] tmin, input logic [TimeW-1:0] tmax,
                           input logic [TimeW-1:0] hmin, input logic [TimeW-1:0] hmax,
                           input logic [TimeW-1:0] win, input bit junk);
    cfg_write(CFG_TEMP_MIN, tmin);
    cfg_write(CFG_TEMP_MAX, tmax);
    cfg_write(CFG_HUM_MIN, hmin);
    cfg_write(CFG_HUM_MAX, hmax);
    cfg_write(CFG_STAR_WINDOW, win);
    if (junk) begin
      for (int u = CFG_STAR_WINDOW + 1; u < (1 << CfgIdxW); u++) begin
        cfg_write(CfgIdxW'(u), $urandom);
      end
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_random(input int count);
    int stop;
    int pick;
    int n;
    logic [TimeW-1:0] dt;
    stop = sent_items + count;
    while (sent_items < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        // optional star, optional second star (sometimes near the window edge), digits, confirm
        if ($urandom_range(0, 2) != 0) press_key(KEY_STAR, short_dt());
        if ($urandom_range(0, 3) == 0) begin
          if ($urandom_range(0, 1) == 1) dt = win_setting - 32'd2 + $urandom_range(0, 4);
          else dt = short_dt();
          press_key(KEY_STAR, dt);
        end
        n = $urandom_range(1, MAX_DIGITS + 1);
        repeat (n) press_key(digit_key($urandom_range(0, 9)), short_dt());
        press_key(($urandom_range(0, 1) == 1) ? KEY_STAR : KEY_HASH, short_dt());
      end else if (pick < 80) begin
        press_key(($urandom_range(0, 1) == 1) ? KEY_STAR : KEY_HASH, short_dt());
      end else begin
        send_scan(KeyW'($urandom_range(0, (1 << KeyW) - 1)),
                  ($urandom_range(0, 3) == 0) ? $urandom : short_dt());
      end
    end
  endtask

  // receiver: stall pattern of its own, plus one long hold-off on request
  initial begin : receiver
    int seg;
    int style;
    int tick;
    bit held;
    tick = 0;
    held = 1'b0;
    forever begin
      seg = $urandom_range(1, 80);
      style = $urandom_range(0, 3);
      repeat (seg) begin
        @(posedge clk_i);
        tick++;
        case (style)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= ($urandom_range(0, 1) == 1);
          2: out_ready_i <= ($urandom_range(0, 4) == 0);
          default: out_ready_i <= (tick % 3 != 0);
        endcase
      end
      if (hold_req && !held) begin
        held = 1'b1;
        repeat (HOLD_CYCLES) begin
          @(posedge clk_i);
          out_ready_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[keypad_setpoint_entry] ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // no key, all keys at once, held keys, digit entry and confirm
    send_scan('0, '0);
    send_scan('1, 5);
    send_scan('1, 5);
    send_scan('0, 5);
    send_scan(key_mask(digit_key(2)), 5);
    send_scan(key_mask(KEY_STAR), 5);
    send_scan(key_mask(KEY_HASH), 5);
    // second star inside the window, humidity entry
    send_scan(key_mask(KEY_STAR), 100);
    send_scan('0, '0);
    send_scan(key_mask(KEY_STAR), 500);
    send_scan(key_mask(digit_key(5)), 5);
    send_scan(key_mask(digit_key(0)), 5);
    send_scan(key_mask(KEY_HASH), 5);
    // second star outside the window
    send_scan(key_mask(KEY_STAR), 5);
    send_scan('0, 20000);
    send_scan(key_mask(KEY_STAR), '0);
    // entry full, then out of range
    repeat (MAX_DIGITS) begin
      send_scan(key_mask(digit_key(9)), 5);
      send_scan('0, 5);
    end
    send_scan(key_mask(digit_key(9)), 5);
    send_scan(key_mask(KEY_STAR), 5);

    run_random(RANDOM_PER_PHASE);
    drain();

    configure(0, 9999, 0, 9999, 0, 1'b0);
    hold_req = 1'b1;
    run_random(RANDOM_PER_PHASE);
    drain();

    // reversed limits
    configure(9999, 0, 90, 20, 32'hFFFF_FFFF, 1'b1);
    run_random(RANDOM_PER_PHASE);
    drain();

    configure(25, 32'hFFFF_C000 | 32'd25, 7, 7, 1, 1'b0);
    run_random(RANDOM_PER_PHASE);
    drain();

    repeat (2) begin
      configure($urandom_range(0, 40), $urandom_range(10, 999), $urandom_range(0, 60),
                $urandom_range(20, 999), $urandom_range(0, 20000), 1'b1);
      run_random(RANDOM_PER_PHASE);
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[keypad_setpoint_entry] OK");
    end else begin
      $display("[keypad_setpoint_entry] ERROR");
    end
    $finish;
  end

endmodule
